[rtl/sps_pkg.sv]
package sps_pkg;

  localparam int unsigned StepsW    = 16;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned PosW      = 12;
  localparam int unsigned CoilW     = 4;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // request kinds
  localparam logic ActMove = 1'b0;
  localparam logic ActTick = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegStepInterval = 2'd0;
  localparam logic [CfgIdxW-1:0] RegStepsPerRev  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegStepMode     = 2'd2;

  localparam logic ModeHalf = 1'b0;
  localparam logic ModeFull = 1'b1;

  localparam logic [IntervalW-1:0] IntervalRst    = 16'd0;
  localparam logic [PosW-1:0]      StepsPerRevRst = 12'd200;
  localparam logic                 StepModeRst    = ModeFull;

  typedef struct packed {
    logic                     action;
    logic signed [StepsW-1:0] move_steps;
    logic                     axis;
  } in_item_t;

  typedef struct packed {
    logic             coil_axis;
    logic [CoilW-1:0] coils;
    logic             stepped;
    logic             busy_res;
    logic             move_done;
    logic             rejected;
  } res_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_item_t;

  function automatic logic [CoilW-1:0] full_step_pattern(input logic [1:0] phase);
    logic [CoilW-1:0] pat;
    case (phase)
      2'd0:    pat = 4'h5;
      2'd1:    pat = 4'h6;
      2'd2:    pat = 4'hA;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

  function automatic logic [CoilW-1:0] half_step_pattern(input logic [2:0] phase);
    logic [CoilW-1:0] pat;
    case (phase)
      3'd0:    pat = 4'h5;
      3'd1:    pat = 4'h4;
      3'd2:    pat = 4'h6;
      3'd3:    pat = 4'h2;
      3'd4:    pat = 4'hA;
      3'd5:    pat = 4'h8;
      3'd6:    pat = 4'h9;
      default: pat = 4'h1;
    endcase
    return pat;
  endfunction

endpackage

[rtl/sps_if.sv]
interface sps_in_if
  import sps_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sps_res_if
  import sps_pkg::*;
();
  logic      valid;
  logic      ready;
  res_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sps_cfg_if
  import sps_pkg::*;
();
  logic      valid;
  logic      ready;
  cfg_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/stepper_phase_sequencer.sv]
// Two-axis stepper phase sequencer.
// Requests arrive on in_req_i: a move command (signed step count and axis)
// or a one-millisecond tick. Every request yields exactly one result on
// res_o: the axis shown, its 4-bit coil pattern and status flags
// (stepped, busy, move done, command rejected).
// Configuration writes on cfg_i (step interval, steps per revolution,
// step mode) are always taken (cfg_i ready is tied high) and are meant for idle time.
// A request accepted on in_req_i is held in the input register, loaded
// into the result register when it advances, and then offered on res_o
// (one input register, one result register, table and counter logic
// between them). Throughput: one request per cycle while res_o is taken.
// When the receiver stalls, the result register holds, the input register
// fills, and in_req_i ready drops until the result is taken.
// Reset: no move pending, position 0, both coil patterns 0, elapsed time
// saturated, interval 0, 200 steps per revolution, full-step mode.
module stepper_phase_sequencer
  import sps_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  sps_in_if.sink   in_req_i,
  sps_res_if.source res_o,
  sps_cfg_if.sink  cfg_i
);

  logic [IntervalW-1:0] step_interval_q;
  logic [PosW-1:0]      steps_per_rev_q;
  logic                 step_mode_q;

  logic [StepsW-1:0]    steps_remaining_q, steps_remaining_d;
  logic                 move_forward_q, move_forward_d;
  logic [PosW-1:0]      position_q, position_d;
  logic [IntervalW-1:0] elapsed_q, elapsed_d;
  logic                 active_axis_q, active_axis_d;
  logic [CoilW-1:0]     coil_latch_q [2];
  logic [CoilW-1:0]     new_pattern;
  logic                 latch_we;

  logic      in_valid_q;
  in_item_t  in_q;
  logic      res_valid_q;
  res_item_t res_q, res_d;
  logic      advance;

  logic [StepsW-1:0]    magnitude;
  logic [IntervalW-1:0] elapsed_inc;
  logic [PosW-1:0]      pos_fwd, pos_base;
  logic                 busy;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_interval_q <= IntervalRst;
      steps_per_rev_q <= StepsPerRevRst;
      step_mode_q     <= StepModeRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        RegStepInterval: step_interval_q <= cfg_i.data.data;
        RegStepsPerRev:  steps_per_rev_q <= cfg_i.data.data[PosW-1:0];
        RegStepMode:     step_mode_q     <= cfg_i.data.data[0];
        default: ;
      endcase
    end
  end

  // the input register moves on when the result register is free or drains
  assign advance        = in_valid_q && (!res_valid_q || res_o.ready);
  assign in_req_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_req_i.ready) begin
      in_valid_q <= in_req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_req_i.valid && in_req_i.ready) begin
      in_q <= in_req_i.data;
    end
  end

  assign busy        = (steps_remaining_q != '0);
  assign magnitude   = in_q.move_steps[StepsW-1] ? (~in_q.move_steps + 1'b1)
                                                 : in_q.move_steps;
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
  assign pos_fwd     = position_q + 1'b1;
  assign pos_base    = (position_q == '0) ? steps_per_rev_q : position_q;

  always_comb begin
    steps_remaining_d = steps_remaining_q;
    move_forward_d    = move_forward_q;
    position_d        = position_q;
    elapsed_d         = elapsed_q;
    active_axis_d     = active_axis_q;
    latch_we          = 1'b0;
    new_pattern       = '0;

    res_d.coil_axis = active_axis_q;
    res_d.stepped   = 1'b0;
    res_d.move_done = 1'b0;
    res_d.rejected  = 1'b0;

    if (in_q.action == ActMove) begin
      res_d.coil_axis = in_q.axis;
      if (busy) begin
        res_d.rejected = 1'b1;
      end else begin
        if (in_q.move_steps != '0) begin
          move_forward_d    = !in_q.move_steps[StepsW-1];
          steps_remaining_d = magnitude;
        end
        active_axis_d = in_q.axis;
      end
    end else begin
      elapsed_d = elapsed_inc;
      if (busy && (elapsed_inc >= step_interval_q)) begin
        elapsed_d         = '0;
        steps_remaining_d = steps_remaining_q - 1'b1;
        if (move_forward_q) begin
          position_d = (pos_fwd == steps_per_rev_q) ? '0 : pos_fwd;
        end else begin
          position_d = pos_base - 1'b1;
        end
        new_pattern = (step_mode_q == ModeFull) ? full_step_pattern(position_d[1:0])
                                                : half_step_pattern(position_d[2:0]);
        latch_we        = 1'b1;
        res_d.stepped   = 1'b1;
        res_d.move_done = (steps_remaining_d == '0);
      end
    end

    res_d.coils    = latch_we ? new_pattern : coil_latch_q[res_d.coil_axis];
    res_d.busy_res = (steps_remaining_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_remaining_q <= '0;
      move_forward_q    <= 1'b0;
      position_q        <= '0;
      elapsed_q         <= '1;
      active_axis_q     <= 1'b0;
      coil_latch_q[0]   <= '0;
      coil_latch_q[1]   <= '0;
    end else if (advance) begin
      steps_remaining_q <= steps_remaining_d;
      move_forward_q    <= move_forward_d;
      position_q        <= position_d;
      elapsed_q         <= elapsed_d;
      active_axis_q     <= active_axis_d;
      if (latch_we) begin
        coil_latch_q[active_axis_q] <= new_pattern;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

endmodule
